@@ hdl/ber_tag_length_header_parser_assert.svh @@
// Assertion macros for the BER header parser checker.
`ifndef BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH
`define BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define BTHP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define BTHP_ASSERT_NEXT(lbl, clk, rst, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (trig) |=> (prop)) else $error(msg);

`endif

@@ hdl/bthp_pkg.sv @@
// Shared types and constants of the BER tag/length header parser.
package bthp_pkg;

  localparam int LEN_BYTES_DEF = 4;
  localparam int TAG_BITS_DEF  = 32;

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_EOC = 1'b1;

  localparam logic [7:0] ID_LONG_MASK = 8'h1F;
  localparam logic [7:0] CONS_MASK    = 8'h20;
  localparam logic [7:0] CLASS_MASK   = 8'hC0;
  localparam logic [7:0] LEN_INDEF    = 8'h80;
  localparam logic [7:0] LOW7_MASK    = 8'h7F;
  localparam logic [7:0] LEN_RESERVED = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MORE = 2'd1,
    ST_BAD  = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       stream_end;
  } bthp_item_t;

  typedef struct packed {
    status_e     status;
    logic        is_eoc_result;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [31:0] tag_number;
    logic        length_indefinite;
    logic [31:0] length_value;
    logic [3:0]  header_bytes;
  } bthp_result_t;

endpackage

@@ hdl/bthp_if.sv @@
// Stream interfaces of the BER header parser: octet input and header result output.
interface bthp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, kind, data_byte, stream_end, input ready);
  modport sink (input valid, kind, data_byte, stream_end, output ready);
endinterface

interface bthp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        is_eoc_result;
  logic [1:0]  tag_class;
  logic        constructed;
  logic [31:0] tag_number;
  logic        length_indefinite;
  logic [31:0] length_value;
  logic [3:0]  header_bytes;

  modport source (output valid, status, is_eoc_result, tag_class, constructed, tag_number,
                  length_indefinite, length_value, header_bytes, input ready);
  modport sink (input valid, status, is_eoc_result, tag_class, constructed, tag_number,
                length_indefinite, length_value, header_bytes, output ready);
endinterface

@@ hdl/ber_tag_length_header_parser.sv @@
// Top level of the BER identifier/length header parser.
//
//   channel | role   | payload
//   in_i    | sink   | kind, data_byte, stream_end
//   out_o   | source | status, is_eoc_result, tag_class, constructed, tag_number,
//           |        | length_indefinite, length_value, header_bytes
//
// One octet per cycle is taken while the result register has room; each octet is held
// in the input register, then decoded, and its result, if any, goes to the result register.
// Octets that only advance a header, and a first end-of-content zero, give no result.
// Reset clears the decode state and both stage valid flags; no clearing pass is needed.
// A stalled result holds in the result register; ready then drops back through the
// input stage, so nothing is lost while the sink waits.
module ber_tag_length_header_parser import bthp_pkg::*; #(
  parameter int LEN_BYTES = LEN_BYTES_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  bthp_in_if.sink     in_i,
  bthp_out_if.source  out_o
);

  bthp_item_t   in_item;
  bthp_item_t   held_item;
  logic         held_valid;
  logic         out_space;
  logic         step;
  logic         res_valid;
  bthp_result_t res;
  bthp_result_t out_res;

  assign in_item.kind       = in_i.kind;
  assign in_item.data_byte  = in_i.data_byte;
  assign in_item.stream_end = in_i.stream_end;

  assign step = held_valid && out_space;

  bthp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (step),
    .item_o  (held_item)
  );

  bthp_core #(
    .LEN_BYTES (LEN_BYTES),
    .TAG_BITS  (TAG_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bthp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .space_o (out_space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.status            = out_res.status;
  assign out_o.is_eoc_result     = out_res.is_eoc_result;
  assign out_o.tag_class         = out_res.tag_class;
  assign out_o.constructed       = out_res.constructed;
  assign out_o.tag_number        = out_res.tag_number;
  assign out_o.length_indefinite = out_res.length_indefinite;
  assign out_o.length_value      = out_res.length_value;
  assign out_o.header_bytes      = out_res.header_bytes;

endmodule

@@ hdl/bthp_in_reg.sv @@
// Input register stage: captures one octet request and holds it until the core takes it.
module bthp_in_reg import bthp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  bthp_item_t item_i,
  output logic       valid_o,
  input  logic       take_i,
  output bthp_item_t item_o
);

  logic       valid_q;
  bthp_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

@@ hdl/bthp_core.sv @@
// Header decode state and the per-octet step logic.
module bthp_core import bthp_pkg::*; #(
  parameter int LEN_BYTES = LEN_BYTES_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  bthp_item_t   item_i,
  output logic         res_valid_o,
  output bthp_result_t res_o
);

  localparam int TagW = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int LblW = $clog2(LEN_BYTES + 1);

  typedef enum logic [1:0] {
    PH_ID0  = 2'd0,
    PH_IDN  = 2'd1,
    PH_LEN0 = 2'd2,
    PH_LENN = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        class_q, class_d;
  logic              cons_q, cons_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic [LblW-1:0]   lbl_q, lbl_d;
  logic [31:0]       len_q, len_d;
  logic [3:0]        bc_q, bc_d;
  logic              indef_q, indef_d;
  logic              eoc1_q, eoc1_d;

  always_comb begin
    logic [7:0]      b;
    logic [6:0]      low7;
    logic [3:0]      bc_inc;
    logic [LblW-1:0] lbl_next;
    logic            fail;
    status_e         fail_st;
    logic            fin;
    logic            fin_indef;
    logic [31:0]     fin_len;

    b         = item_i.data_byte;
    low7      = b[6:0] & LOW7_MASK[6:0];
    bc_inc    = (bc_q < 4'd15) ? bc_q + 4'd1 : bc_q;
    lbl_next  = lbl_q;
    fail      = 1'b0;
    fail_st   = ST_OK;
    fin       = 1'b0;
    fin_indef = 1'b0;
    fin_len   = '0;

    phase_d = phase_q;
    class_d = class_q;
    cons_d  = cons_q;
    tag_d   = tag_q;
    lbl_d   = lbl_q;
    len_d   = len_q;
    bc_d    = bc_q;
    indef_d = indef_q;
    eoc1_d  = eoc1_q;

    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (item_i.kind == KIND_EOC) begin
        phase_d = PH_ID0;
        res_o.is_eoc_result = 1'b1;
        if (!indef_q) begin
          res_valid_o = 1'b1;
        end else if (b != 8'd0) begin
          eoc1_d       = 1'b0;
          res_valid_o  = 1'b1;
          res_o.status = ST_BAD;
        end else if (eoc1_q) begin
          eoc1_d             = 1'b0;
          res_valid_o        = 1'b1;
          res_o.header_bytes = 4'd2;
        end else if (item_i.stream_end) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_MORE;
        end else begin
          // first closing zero: wait for the second
          eoc1_d = 1'b1;
        end
      end else begin
        eoc1_d = 1'b0;
        unique case (phase_q)
          PH_ID0: begin
            bc_d    = 4'd1;
            class_d = 2'((b & CLASS_MASK) >> 6);
            cons_d  = (b & CONS_MASK) != 8'd0;
            tag_d   = '0;
            len_d   = '0;
            lbl_d   = '0;
            if ((b & ID_LONG_MASK) != ID_LONG_MASK) begin
              tag_d   = TagW'(b & ID_LONG_MASK);
              phase_d = PH_LEN0;
            end else begin
              phase_d = PH_IDN;
            end
            if (item_i.stream_end) begin
              fail    = 1'b1;
              fail_st = ST_MORE;
            end
          end
          PH_IDN: begin
            bc_d = bc_inc;
            if (bc_q == 4'd1 && low7 == 7'd0) begin
              fail    = 1'b1;
              fail_st = ST_BAD;
            end else if (tag_q[TagW-1 -: 7] != 7'd0) begin
              fail    = 1'b1;
              fail_st = ST_OVF;
            end else begin
              tag_d = {tag_q[TagW-8:0], low7};
              if (!b[7]) begin
                phase_d = PH_LEN0;
              end
              if (item_i.stream_end) begin
                fail    = 1'b1;
                fail_st = ST_MORE;
              end
            end
          end
          PH_LEN0: begin
            bc_d = bc_inc;
            if (!b[7]) begin
              fin     = 1'b1;
              fin_len = 32'(b);
            end else if (b == LEN_INDEF) begin
              fin       = 1'b1;
              fin_indef = 1'b1;
            end else if (b == LEN_RESERVED) begin
              fail    = 1'b1;
              fail_st = ST_BAD;
            end else if (low7 > 7'(LEN_BYTES)) begin
              fail    = 1'b1;
              fail_st = ST_OVF;
            end else begin
              lbl_d   = LblW'(low7);
              len_d   = '0;
              phase_d = PH_LENN;
              if (item_i.stream_end) begin
                fail    = 1'b1;
                fail_st = ST_MORE;
              end
            end
          end
          PH_LENN: begin
            bc_d = bc_inc;
            if (len_q[31:24] != 8'd0) begin
              fail    = 1'b1;
              fail_st = ST_OVF;
            end else begin
              len_d    = {len_q[23:0], b};
              lbl_next = (lbl_q != '0) ? lbl_q - 1'b1 : lbl_q;
              lbl_d    = lbl_next;
              if (lbl_next == '0) begin
                fin     = 1'b1;
                fin_len = {len_q[23:0], b};
              end else if (item_i.stream_end) begin
                fail    = 1'b1;
                fail_st = ST_MORE;
              end
            end
          end
        endcase

        if (fail) begin
          // drop the header and restart at an identifier octet
          phase_d            = PH_ID0;
          res_valid_o        = 1'b1;
          res_o.status       = fail_st;
          res_o.header_bytes = bc_d;
        end else if (fin) begin
          phase_d                 = PH_ID0;
          indef_d                 = fin_indef;
          res_valid_o             = 1'b1;
          res_o.tag_class         = class_q;
          res_o.constructed       = cons_q;
          res_o.tag_number        = 32'(tag_q);
          res_o.length_indefinite = fin_indef;
          res_o.length_value      = fin_len;
          res_o.header_bytes      = bc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID0;
      class_q <= '0;
      cons_q  <= 1'b0;
      tag_q   <= '0;
      lbl_q   <= '0;
      len_q   <= '0;
      bc_q    <= '0;
      indef_q <= 1'b0;
      eoc1_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      class_q <= class_d;
      cons_q  <= cons_d;
      tag_q   <= tag_d;
      lbl_q   <= lbl_d;
      len_q   <= len_d;
      bc_q    <= bc_d;
      indef_q <= indef_d;
      eoc1_q  <= eoc1_d;
    end
  end

endmodule

@@ hdl/bthp_out_reg.sv @@
// Result register: holds one finished result until the sink takes it.
module bthp_out_reg import bthp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  bthp_result_t res_i,
  output logic         space_o,
  output logic         valid_o,
  input  logic         ready_i,
  output bthp_result_t res_o
);

  logic         valid_q;
  bthp_result_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ hdl/bthp_checker.sv @@
// Port-level checks of the BER header parser, bound to the top level.
`include "ber_tag_length_header_parser_assert.svh"

module bthp_port_checker import bthp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic        is_eoc_result_i,
  input logic [1:0]  tag_class_i,
  input logic        constructed_i,
  input logic [31:0] tag_number_i,
  input logic        length_indefinite_i,
  input logic [31:0] length_value_i,
  input logic [3:0]  header_bytes_i
);

  logic        hdr_ok;
  logic        hdr_fail;
  logic        eoc_res;
  logic        out_stall;
  logic [74:0] res_bits;
  logic        ok_good;
  logic        fields_clear;
  logic        eoc_good;

  assign hdr_ok    = out_valid_i && !is_eoc_result_i && status_i == ST_OK;
  assign hdr_fail  = out_valid_i && !is_eoc_result_i && status_i != ST_OK;
  assign eoc_res   = out_valid_i && is_eoc_result_i;
  assign out_stall = out_valid_i && !out_ready_i;

  assign res_bits = {status_i, is_eoc_result_i, tag_class_i, constructed_i, tag_number_i,
                     length_indefinite_i, length_value_i, header_bytes_i};

  assign ok_good = header_bytes_i >= 4'd2 && (!length_indefinite_i || length_value_i == 32'd0);

  assign fields_clear = tag_class_i == 2'd0 && !constructed_i && tag_number_i == 32'd0 &&
                        !length_indefinite_i && length_value_i == 32'd0;

  assign eoc_good = tag_number_i == 32'd0 && length_value_i == 32'd0 && status_i != ST_OVF &&
                    (header_bytes_i == 4'd0 || (header_bytes_i == 4'd2 && status_i == ST_OK));

  // a stalled result keeps its value
  `BTHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(res_bits), "stalled result changed")

  // a finished header spans identifier and length octets; indefinite carries no length
  `BTHP_ASSERT(a_hdr_ok, clk_i, rst_ni, !hdr_ok || ok_good, "bad finished header")

  // a failed header reports only its status and octet count
  `BTHP_ASSERT(a_hdr_fail, clk_i, rst_ni, !hdr_fail || (fields_clear && header_bytes_i != 4'd0), "failed header carries fields")

  // end-of-content results: no tag number or length value, count only on the closing pair
  `BTHP_ASSERT(a_eoc, clk_i, rst_ni, !eoc_res || eoc_good, "bad end-of-content result")

endmodule

bind ber_tag_length_header_parser bthp_port_checker u_bthp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .status_i            (out_o.status),
  .is_eoc_result_i     (out_o.is_eoc_result),
  .tag_class_i         (out_o.tag_class),
  .constructed_i       (out_o.constructed),
  .tag_number_i        (out_o.tag_number),
  .length_indefinite_i (out_o.length_indefinite),
  .length_value_i      (out_o.length_value),
  .header_bytes_i      (out_o.header_bytes)
);
